// File: sv/bmsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bus-mapped signed divider.
// Used by the register file, the serial divider and the top level.
package bmsd_pkg;

	localparam int DATA_W       = 16;
	localparam int NUM_UNITS_DEF = 2;
	localparam int DIV_STEPS    = 32;
	localparam int CNT_W        = $clog2(DIV_STEPS);

	// Write register select, offset modulo 4
	localparam logic [1:0] WR_DIV_HIGH = 2'd0;
	localparam logic [1:0] WR_DIV_LOW  = 2'd1;
	localparam logic [1:0] WR_DIVISOR  = 2'd2;
	localparam logic [1:0] WR_NONE     = 2'd3;

	// Read register select, offset modulo 8
	localparam logic [2:0] RD_DIV_HIGH = 3'd0;
	localparam logic [2:0] RD_DIV_LOW  = 3'd1;
	localparam logic [2:0] RD_DIVISOR  = 3'd2;
	localparam logic [2:0] RD_RES_HIGH = 3'd4;
	localparam logic [2:0] RD_RES_LOW  = 3'd5;
	localparam logic [2:0] RD_STATUS   = 3'd6;

	localparam logic [DATA_W-1:0] FLAG_DIV_ZERO = 16'h4000;
	localparam logic [DATA_W-1:0] FLAG_SAT      = 16'h8000;
	localparam logic [DATA_W-1:0] NO_REG        = 16'hffff;
	localparam logic [DATA_W-1:0] SAT_POS       = 16'h7fff;
	localparam logic [DATA_W-1:0] SAT_NEG       = 16'h8000;
	localparam logic [31:0]       MAG_POS_MAX   = 32'd32767;
	localparam logic [31:0]       MAG_NEG_MAX   = 32'd32768;

	typedef struct packed {
		logic              we;
		logic [1:0]        sel;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] keep;
		logic              mode_we;
		logic              mode;
	} bmsd_wr_t;

	typedef struct packed {
		logic              res_we;
		logic              stat_we;
		logic [DATA_W-1:0] res_high;
		logic [DATA_W-1:0] res_low;
		logic [DATA_W-1:0] status;
	} bmsd_upd_t;

	typedef struct packed {
		logic [DATA_W-1:0] div_high;
		logic [DATA_W-1:0] div_low;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] res_high;
		logic [DATA_W-1:0] res_low;
		logic [DATA_W-1:0] status;
		logic              mode;
	} bmsd_view_t;

	typedef struct packed {
		logic              done;
		logic [31:0]       quo;
		logic [DATA_W-1:0] rem;
		logic              sat;
	} bmsd_div_res_t;

endpackage

// File: sv/bmsd_regs.sv
`timescale 1ns / 1ps
// Register file of one divider unit: operands, results, status and mode.
// Depends on bmsd_pkg for the write, update and view structs.
module bmsd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bmsd_pkg::bmsd_wr_t  wr,
	input  logic                upd_en,
	input  bmsd_pkg::bmsd_upd_t upd,
	output bmsd_pkg::bmsd_view_t view
);
	import bmsd_pkg::*;

	logic [DATA_W-1:0] div_high_q, div_low_q, divisor_q;
	logic [DATA_W-1:0] res_high_q, res_low_q, status_q;
	logic              mode_q;
	logic [DATA_W-1:0] merged;
	logic [DATA_W-1:0] old_word;

	always_comb begin
		case (wr.sel)
			WR_DIV_HIGH: old_word = div_high_q;
			WR_DIV_LOW:  old_word = div_low_q;
			WR_DIVISOR:  old_word = divisor_q;
			default:     old_word = '0;
		endcase
		merged = (old_word & wr.keep) | (wr.data & ~wr.keep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_high_q <= '0;
			div_low_q  <= '0;
			divisor_q  <= '0;
			res_high_q <= '0;
			res_low_q  <= '0;
			status_q   <= '0;
			mode_q     <= 1'b0;
		end else begin
			if (wr_en && wr.we) begin
				case (wr.sel)
					WR_DIV_HIGH: div_high_q <= merged;
					WR_DIV_LOW:  div_low_q  <= merged;
					WR_DIVISOR:  divisor_q  <= merged;
					default:     ;
				endcase
				if (wr.mode_we) mode_q <= wr.mode;
			end
			if (upd_en && upd.res_we) begin
				res_high_q <= upd.res_high;
				res_low_q  <= upd.res_low;
			end
			if (upd_en && upd.stat_we) status_q <= upd.status;
		end
	end

	assign view = '{div_high: div_high_q, div_low: div_low_q, divisor: divisor_q,
	                res_high: res_high_q, res_low: res_low_q, status: status_q,
	                mode: mode_q};

endmodule

// File: sv/bmsd_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for signed 32/16, one quotient bit per cycle.
// Depends on bmsd_pkg for widths and the result struct.
module bmsd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               dividend,
	input  logic [bmsd_pkg::DATA_W-1:0] divisor,
	output bmsd_pkg::bmsd_div_res_t   res
);
	import bmsd_pkg::*;

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       dq_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dmag_q;
	logic              n_neg_q, q_neg_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;
	logic [31:0]       quo;

	assign shifted = {rem_q, dq_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: take magnitudes on start, then shift one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			n_neg_q <= dividend[31];
			q_neg_q <= dividend[31] ^ divisor[DATA_W-1];
			dq_q    <= dividend[31] ? (32'd0 - dividend) : dividend;
			dmag_q  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			rem_q <= diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			dq_q  <= {dq_q[30:0], ~diff[DATA_W+1]};
		end
	end

	assign quo = q_neg_q ? (32'd0 - dq_q) : dq_q;

	assign res = '{done: done_q,
	               quo:  quo,
	               rem:  n_neg_q ? (DATA_W'(0) - rem_q) : rem_q,
	               sat:  q_neg_q ? (dq_q > MAG_NEG_MAX) : (dq_q > MAG_POS_MAX)};

endmodule

// File: sv/bus_mapped_signed_divider.sv
`timescale 1ns / 1ps
// Bus-mapped signed divider: NUM_UNITS register sets sharing one serial divider.
// Reads and writes that need no recompute go straight to the finish state; a
// write that recomputes loads the operands and, with a nonzero divisor, runs the
// shared divider, which produces one quotient bit per cycle, one item at a time.
// Asynchronous active-low reset clears all unit registers and the control state.
// Depends on bmsd_pkg, bmsd_regs and bmsd_div.
module bus_mapped_signed_divider #(
	parameter int NUM_UNITS = bmsd_pkg::NUM_UNITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          opcode,
	input  logic                          unit,
	input  logic [3:0]                    reg_offset,
	input  logic [bmsd_pkg::DATA_W-1:0]   write_data,
	input  logic [bmsd_pkg::DATA_W-1:0]   keep_mask,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bmsd_pkg::DATA_W-1:0]   read_data
);
	import bmsd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q;
	logic              opcode_q, unit_q;
	logic [3:0]        offset_q;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] read_data_q;

	logic              accept, unit_ok_in, write_go, out_free;
	bmsd_wr_t          wr;
	bmsd_upd_t         upd;
	bmsd_view_t        views [NUM_UNITS];
	bmsd_view_t        view;
	logic              unit_hit;
	logic              div_start;
	bmsd_div_res_t     div_res;
	logic [DATA_W-1:0] result_word;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign unit_ok_in = (32'(unit) < 32'(NUM_UNITS));
	assign write_go   = opcode && unit_ok_in && (reg_offset[1:0] != WR_NONE);
	assign out_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		wr.we      = accept && write_go;
		wr.sel     = reg_offset[1:0];
		wr.data    = write_data;
		wr.keep    = keep_mask;
		wr.mode_we = reg_offset[3] &&
		             (reg_offset[1:0] == WR_DIV_LOW || reg_offset[1:0] == WR_DIVISOR);
		wr.mode    = reg_offset[2];
	end

	for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
		bmsd_regs u_regs (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (32'(unit) == 32'(i)),
			.wr     (wr),
			.upd_en (32'(unit_q) == 32'(i)),
			.upd    (upd),
			.view   (views[i])
		);
	end

	always_comb begin
		view     = '0;
		unit_hit = 1'b0;
		for (int i = 0; i < NUM_UNITS; i++) begin
			if (32'(unit_q) == 32'(i)) begin
				view     = views[i];
				unit_hit = 1'b1;
			end
		end
	end

	assign div_start = (state_q == ST_LOAD) && (view.divisor != '0);

	bmsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({view.div_high, view.div_low}),
		.divisor  (view.divisor),
		.res      (div_res)
	);

	// Result and status writeback of the addressed unit
	always_comb begin
		upd = '0;
		if (state_q == ST_LOAD && view.divisor == '0) begin
			upd.stat_we = 1'b1;
			upd.status  = FLAG_DIV_ZERO;
		end else if (state_q == ST_DIV && div_res.done) begin
			upd.stat_we = 1'b1;
			upd.res_we  = 1'b1;
			if (view.mode) begin
				upd.res_high = div_res.quo[31:16];
				upd.res_low  = div_res.quo[15:0];
				upd.status   = '0;
			end else begin
				// clamp by the operand signs: a positive 2^31 quotient has bit 31 set
				upd.res_high = div_res.sat ?
				               ((view.div_high[DATA_W-1] ^ view.divisor[DATA_W-1]) ?
				                SAT_NEG : SAT_POS)
				               : div_res.quo[15:0];
				upd.res_low  = div_res.rem;
				upd.status   = div_res.sat ? FLAG_SAT : '0;
			end
		end
	end

	always_comb begin
		if (opcode_q) begin
			result_word = '0;
		end else if (!unit_hit) begin
			result_word = NO_REG;
		end else begin
			case (offset_q[2:0])
				RD_DIV_HIGH: result_word = view.div_high;
				RD_DIV_LOW:  result_word = view.div_low;
				RD_DIVISOR:  result_word = view.divisor;
				RD_RES_HIGH: result_word = view.res_high;
				RD_RES_LOW:  result_word = view.res_low;
				RD_STATUS:   result_word = view.status;
				default:     result_word = NO_REG;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (accept) state_q <= write_go ? ST_LOAD : ST_FIN;
				ST_LOAD: state_q <= (view.divisor == '0) ? ST_FIN : ST_DIV;
				ST_DIV:  if (div_res.done) state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the accepted item and the pending result word
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= opcode;
			unit_q   <= unit;
			offset_q <= reg_offset;
		end
		if (state_q == ST_FIN && out_free) read_data_q <= result_word;
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_write_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && write_go) |=> state_q == ST_LOAD)
		else $error("recompute write did not start operand load");

	a_zero_keeps_results: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.stat_we && upd.status == FLAG_DIV_ZERO) |-> !upd.res_we)
		else $error("zero divisor changed the results");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result presented without finishing an item");
`endif

endmodule
